FILE: hw/rtl/second_best_spanning_tree_cost_defines.svh
// Assertion macros used by the port-level checker file
`ifndef SECOND_BEST_SPANNING_TREE_COST_DEFINES_SVH
`define SECOND_BEST_SPANNING_TREE_COST_DEFINES_SVH

// same-cycle implication
`define SBST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sbst_pkg.sv
// Shared types and constants for the second-best spanning tree cost block
package sbst_pkg;

    localparam int CFG_W           = 7;
    localparam int COST_W          = 26;
    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 20;
    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_ROUND, ST_SCAN_RD, ST_SCAN_CMP,
        ST_FIND_A, ST_FIND_B, ST_FIND_C, ST_CHECK, ST_MP_RD, ST_MP_CMP,
        ST_MERGE, ST_X_RD, ST_X_CHK, ST_X_NEXT, ST_Y_RD, ST_Y_CHK,
        ST_RL_START, ST_RL_RD, ST_RL_CHK, ST_NEXT, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_ROUND, OP_SCAN_RD, OP_SCAN_CMP,
        OP_FIND_A, OP_FIND_B, OP_FIND_C, OP_MP_RD, OP_MP_CMP,
        OP_MERGE, OP_X_RD, OP_X_CHK, OP_X_NEXT, OP_Y_RD, OP_Y_CHK,
        OP_RL_START, OP_RL_RD, OP_RL_CHK, OP_NEXT, OP_DONE
    } op_t;

    typedef struct packed {
        logic x_last;
        logic y_last;
        logic k_last;
        logic rounds_last;
        logic roots_differ;
        logic label_is_ra;
        logic label_is_rb;
    } sbst_status_t;

endpackage

FILE: hw/rtl/sbst_ram.sv
// Generic single-write, single-read RAM with registered read data
module sbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/sbst_ctrl.sv
// Controller state machine sequencing load, edge scan, union and result
module sbst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  final_edge,
    input  sbst_pkg::sbst_status_t status,
    output logic                  busy,
    output sbst_pkg::op_t         op
);
    import sbst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op = OP_LOAD;
                    if (final_edge)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                op = OP_INIT;
                if (status.x_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                op         = OP_ROUND;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                op         = OP_SCAN_CMP;
                state_next = status.k_last ? ST_FIND_A : ST_SCAN_RD;
            end
            ST_FIND_A:
            begin
                op         = OP_FIND_A;
                state_next = ST_FIND_B;
            end
            ST_FIND_B:
            begin
                op         = OP_FIND_B;
                state_next = ST_FIND_C;
            end
            ST_FIND_C:
            begin
                op         = OP_FIND_C;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.roots_differ ? ST_MERGE : ST_MP_RD;
            end
            ST_MP_RD:
            begin
                op         = OP_MP_RD;
                state_next = ST_MP_CMP;
            end
            ST_MP_CMP:
            begin
                op         = OP_MP_CMP;
                state_next = ST_NEXT;
            end
            ST_MERGE:
            begin
                op         = OP_MERGE;
                state_next = ST_X_RD;
            end
            ST_X_RD:
            begin
                op         = OP_X_RD;
                state_next = ST_X_CHK;
            end
            ST_X_CHK:
            begin
                op = OP_X_CHK;
                if (status.label_is_ra)
                begin
                    state_next = ST_Y_RD;
                end
                else if (status.x_last)
                begin
                    state_next = ST_RL_START;
                end
                else
                begin
                    state_next = ST_X_NEXT;
                end
            end
            ST_X_NEXT:
            begin
                op         = OP_X_NEXT;
                state_next = ST_X_RD;
            end
            ST_Y_RD:
            begin
                op         = OP_Y_RD;
                state_next = ST_Y_CHK;
            end
            ST_Y_CHK:
            begin
                op = OP_Y_CHK;
                if (!status.y_last)
                begin
                    state_next = ST_Y_RD;
                end
                else if (status.x_last)
                begin
                    state_next = ST_RL_START;
                end
                else
                begin
                    state_next = ST_X_NEXT;
                end
            end
            ST_RL_START:
            begin
                op         = OP_RL_START;
                state_next = ST_RL_RD;
            end
            ST_RL_RD:
            begin
                op         = OP_RL_RD;
                state_next = ST_RL_CHK;
            end
            ST_RL_CHK:
            begin
                op         = OP_RL_CHK;
                state_next = status.x_last ? ST_NEXT : ST_RL_RD;
            end
            ST_NEXT:
            begin
                op         = OP_NEXT;
                state_next = status.rounds_last ? ST_DONE : ST_ROUND;
            end
            ST_DONE:
            begin
                op         = OP_DONE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: hw/rtl/sbst_dp.sv
// Datapath: weight, label and path-max stores, counters and accumulators
module sbst_dp #(
    parameter int MAX_NODES   = sbst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = sbst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbst_pkg::op_t               op,
    input  logic                        cfg_we,
    input  logic [sbst_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic [WEIGHT_BITS-1:0]      edge_weight,
    output sbst_pkg::sbst_status_t      status,
    output logic                        result_valid,
    output logic [sbst_pkg::COST_W-1:0] second_best_cost,
    output logic                        no_alternative
);
    import sbst_pkg::*;

    localparam int MAX_EDGES = (MAX_NODES * (MAX_NODES - 1)) / 2;
    localparam int NB  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EB  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int WB  = WEIGHT_BITS;
    localparam int XW  = WEIGHT_BITS + 1;
    localparam int MAW = 2 * NB;

    logic [CFG_W-1:0]  node_count_reg, node_count_next;
    logic [EB-1:0]     load_count_reg, load_count_next;
    logic [NB-1:0]     nm1_reg, nm1_next;
    logic [EB-1:0]     edges_reg, edges_next;
    logic [NB-1:0]     x_reg, x_next, y_reg, y_next;
    logic [NB-1:0]     a_reg, a_next, b_reg, b_next;
    logic [NB-1:0]     ba_reg, ba_next, bb_reg, bb_next;
    logic [NB-1:0]     ra_reg, ra_next, rb_reg, rb_next;
    logic [EB-1:0]     k_reg, k_next, bk_reg, bk_next, lk_reg, lk_next;
    logic [EB-1:0]     rounds_reg, rounds_next;
    logic [WB-1:0]     bw_reg, bw_next, lw_reg, lw_next;
    logic              found_reg, found_next, have_last_reg, have_last_next;
    logic [COST_W-1:0] tree_total_reg, tree_total_next;
    logic [XW-1:0]     best_extra_reg, best_extra_next;
    logic              result_valid_reg, result_valid_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic              no_alt_reg, no_alt_next;

    logic              wram_we;
    logic [EAW-1:0]    wram_waddr, wram_raddr;
    logic [WB-1:0]     wram_rdata;
    logic              lram_we;
    logic [NB-1:0]     lram_waddr, lram_wdata, lram_raddr, lram_rdata;
    logic              mram_we;
    logic [MAW-1:0]    mram_waddr, mram_raddr;
    logic [WB-1:0]     mram_rdata;

    logic [NCW-1:0]    n_clamp;
    logic [EB-1:0]     edges_calc;
    logic [WB-1:0]     w_cur, d_cur;
    logic              after_last, better;

    sbst_ram #(.WIDTH(WB), .DEPTH(MAX_EDGES), .AW(EAW)) u_wram (
        .clk(clk), .we(wram_we), .waddr(wram_waddr), .wdata(edge_weight),
        .raddr(wram_raddr), .rdata(wram_rdata)
    );

    sbst_ram #(.WIDTH(NB), .DEPTH(MAX_NODES), .AW(NB)) u_lram (
        .clk(clk), .we(lram_we), .waddr(lram_waddr), .wdata(lram_wdata),
        .raddr(lram_raddr), .rdata(lram_rdata)
    );

    sbst_ram #(.WIDTH(WB), .DEPTH(1 << MAW), .AW(MAW)) u_mram (
        .clk(clk), .we(mram_we), .waddr(mram_waddr), .wdata(bw_reg),
        .raddr(mram_raddr), .rdata(mram_rdata)
    );

    always_comb
    begin
        if (node_count_reg < CFG_W'(2))
        begin
            n_clamp = NCW'(2);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            n_clamp = NCW'(MAX_NODES);
        end
        else
        begin
            n_clamp = NCW'(node_count_reg);
        end
        edges_calc = EB'((32'(n_clamp) * (32'(n_clamp) - 32'd1)) >> 1);
    end

    assign w_cur = (k_reg < load_count_reg) ? wram_rdata : '0;
    assign d_cur = (bw_reg >= mram_rdata) ? (bw_reg - mram_rdata) : '0;
    assign after_last = !have_last_reg || (w_cur > lw_reg)
                        || ((w_cur == lw_reg) && (k_reg > lk_reg));
    assign better = !found_reg || (w_cur < bw_reg)
                    || ((w_cur == bw_reg) && (k_reg < bk_reg));

    always_comb
    begin
        status.x_last       = (x_reg == nm1_reg);
        status.y_last       = (y_reg == nm1_reg);
        status.k_last       = (k_reg == EB'(edges_reg - EB'(1)));
        status.rounds_last  = (rounds_reg == EB'(edges_reg - EB'(1)));
        status.roots_differ = (ra_reg != rb_reg);
        status.label_is_ra  = (lram_rdata == ra_reg);
        status.label_is_rb  = (lram_rdata == rb_reg);
    end

    always_comb
    begin
        node_count_next   = cfg_we ? cfg_wdata : node_count_reg;
        load_count_next   = load_count_reg;
        nm1_next          = nm1_reg;
        edges_next        = edges_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        ba_next           = ba_reg;
        bb_next           = bb_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;
        k_next            = k_reg;
        bk_next           = bk_reg;
        lk_next           = lk_reg;
        rounds_next       = rounds_reg;
        bw_next           = bw_reg;
        lw_next           = lw_reg;
        found_next        = found_reg;
        have_last_next    = have_last_reg;
        tree_total_next   = tree_total_reg;
        best_extra_next   = best_extra_reg;
        result_valid_next = 1'b0;
        cost_next         = cost_reg;
        no_alt_next       = no_alt_reg;
        wram_we           = 1'b0;
        wram_waddr        = load_count_reg[EAW-1:0];
        wram_raddr        = k_reg[EAW-1:0];
        lram_we           = 1'b0;
        lram_waddr        = x_reg;
        lram_wdata        = x_reg;
        lram_raddr        = x_reg;
        mram_we           = 1'b0;
        mram_waddr        = (x_reg < y_reg) ? {x_reg, y_reg} : {y_reg, x_reg};
        mram_raddr        = {ba_reg, bb_reg};
        case (op)
            OP_LOAD:
            begin
                if (load_count_reg < EB'(MAX_EDGES))
                begin
                    wram_we         = 1'b1;
                    load_count_next = load_count_reg + EB'(1);
                end
                nm1_next       = NB'(n_clamp - NCW'(1));
                edges_next     = edges_calc;
                x_next         = '0;
                have_last_next = 1'b0;
                rounds_next    = '0;
            end
            OP_INIT:
            begin
                lram_we = 1'b1;
                x_next  = x_reg + NB'(1);
            end
            OP_ROUND:
            begin
                k_next     = '0;
                a_next     = '0;
                b_next     = NB'(1);
                found_next = 1'b0;
            end
            OP_SCAN_CMP:
            begin
                if (after_last && better)
                begin
                    bw_next    = w_cur;
                    bk_next    = k_reg;
                    ba_next    = a_reg;
                    bb_next    = b_reg;
                    found_next = 1'b1;
                end
                k_next = k_reg + EB'(1);
                if (b_reg == nm1_reg)
                begin
                    a_next = a_reg + NB'(1);
                    b_next = a_reg + NB'(2);
                end
                else
                begin
                    b_next = b_reg + NB'(1);
                end
            end
            OP_FIND_A:
            begin
                lram_raddr = ba_reg;
            end
            OP_FIND_B:
            begin
                lram_raddr = bb_reg;
                ra_next    = lram_rdata;
            end
            OP_FIND_C:
            begin
                rb_next = lram_rdata;
            end
            OP_MP_CMP:
            begin
                if ({1'b0, d_cur} < best_extra_reg)
                begin
                    best_extra_next = {1'b0, d_cur};
                end
            end
            OP_MERGE:
            begin
                tree_total_next = tree_total_reg + COST_W'(bw_reg);
                x_next          = '0;
            end
            OP_X_CHK:
            begin
                y_next = '0;
            end
            OP_X_NEXT:
            begin
                x_next = x_reg + NB'(1);
            end
            OP_Y_RD:
            begin
                lram_raddr = y_reg;
            end
            OP_Y_CHK:
            begin
                mram_we = status.label_is_rb;
                y_next  = y_reg + NB'(1);
            end
            OP_RL_START:
            begin
                x_next = '0;
            end
            OP_RL_CHK:
            begin
                lram_we    = status.label_is_rb;
                lram_wdata = ra_reg;
                x_next     = x_reg + NB'(1);
            end
            OP_NEXT:
            begin
                lw_next        = bw_reg;
                lk_next        = bk_reg;
                have_last_next = 1'b1;
                rounds_next    = rounds_reg + EB'(1);
            end
            OP_DONE:
            begin
                result_valid_next = 1'b1;
                if (best_extra_reg == '1)
                begin
                    cost_next   = '0;
                    no_alt_next = 1'b1;
                end
                else
                begin
                    cost_next   = tree_total_reg + COST_W'(best_extra_reg);
                    no_alt_next = 1'b0;
                end
                load_count_next = '0;
                tree_total_next = '0;
                best_extra_next = '1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= NODE_COUNT_RESET;
            load_count_reg   <= '0;
            tree_total_reg   <= '0;
            best_extra_reg   <= '1;
            result_valid_reg <= 1'b0;
            found_reg        <= 1'b0;
            have_last_reg    <= 1'b0;
            rounds_reg       <= '0;
        end
        else
        begin
            node_count_reg   <= node_count_next;
            load_count_reg   <= load_count_next;
            tree_total_reg   <= tree_total_next;
            best_extra_reg   <= best_extra_next;
            result_valid_reg <= result_valid_next;
            found_reg        <= found_next;
            have_last_reg    <= have_last_next;
            rounds_reg       <= rounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm1_reg    <= nm1_next;
        edges_reg  <= edges_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ba_reg     <= ba_next;
        bb_reg     <= bb_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        k_reg      <= k_next;
        bk_reg     <= bk_next;
        lk_reg     <= lk_next;
        bw_reg     <= bw_next;
        lw_reg     <= lw_next;
        cost_reg   <= cost_next;
        no_alt_reg <= no_alt_next;
    end

    assign result_valid     = result_valid_reg;
    assign second_best_cost = cost_reg;
    assign no_alternative   = no_alt_reg;
endmodule

FILE: hw/rtl/second_best_spanning_tree_cost.sv
// Second-best spanning tree cost: top level joining controller and datapath.
// Non-final beats are taken while busy stays low, and the next beat may follow.
// On the final beat busy rises until the result; the edge scan over the weight
// RAM's single read port dominates that time.
// Result is a one-cycle strobe on result_valid; busy falls in that same cycle.
// Async reset: node_count = 64, graph empty, no result pending.
module second_best_spanning_tree_cost #(
    parameter int MAX_NODES   = sbst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = sbst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [WEIGHT_BITS-1:0]      edge_weight,
    input  logic                        final_edge,
    input  logic                        cfg_we,
    input  logic [sbst_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                        result_valid,
    output logic [sbst_pkg::COST_W-1:0] second_best_cost,
    output logic                        no_alternative
);
    import sbst_pkg::*;

    op_t          op;
    sbst_status_t status;

    sbst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .final_edge(final_edge),
        .status(status), .busy(busy), .op(op)
    );

    sbst_dp #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .op(op), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .edge_weight(edge_weight), .status(status), .result_valid(result_valid),
        .second_best_cost(second_best_cost), .no_alternative(no_alternative)
    );
endmodule

FILE: hw/rtl/sbst_checker.sv
// Port-level checker for the second-best spanning tree cost block, with bind
`include "second_best_spanning_tree_cost_defines.svh"
module sbst_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic final_edge,
    input logic result_valid
);
    `SBST_ASSERT_NXT(a_single_beat, clk, rst_n, result_valid, !result_valid, "result beat repeated")
    `SBST_ASSERT_NXT(a_plain_load, clk, rst_n, start && !busy && !final_edge, !busy, "busy after plain load")
    `SBST_ASSERT_NXT(a_final_busy, clk, rst_n, start && !busy && final_edge, busy, "final beat not taken")
    `SBST_ASSERT_NOW(a_done_idle, clk, rst_n, result_valid, !busy, "result while busy")
    `SBST_ASSERT_NOW(a_fall_result, clk, rst_n, $fell(busy), result_valid, "busy fell without result")
endmodule

bind second_best_spanning_tree_cost sbst_checker u_sbst_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the second-best spanning tree cost block
module tb_top;
    import sbst_pkg::*;

    localparam int MAXN  = 64;
    localparam int MAXE  = (MAXN * (MAXN - 1)) / 2;
    localparam int WB    = 20;
    localparam longint NO_EXTRA = (64'd1 << (WB + 1)) - 1;
    localparam int LIMIT = 30000000;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              noalt;
    } sbst_result_t;

    typedef struct {
        int          cfg;
        int unsigned weight;
        bit          fin;
        bit          typed;
        int unsigned cost;
        bit          noalt;
    } stim_row_t;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                start = 0;
    logic                busy;
    logic [WB-1:0]       edge_weight = '0;
    logic                final_edge = 0;
    logic                cfg_we = 0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                result_valid;
    logic [COST_W-1:0]   second_best_cost;
    logic                no_alternative;

    sbst_result_t expected_results[$];
    sbst_result_t typed_results[$];
    int   failures = 0;
    int   cycles = 0;
    int   beats_sent = 0;

    // predictor state
    logic [CFG_W-1:0] node_reg = NODE_COUNT_RESET;
    logic [WB-1:0]    weights[MAXE];
    int unsigned      loaded = 0;
    int unsigned      order[MAXE];
    int unsigned      parent[MAXN];
    int unsigned      root_of[MAXN];
    int unsigned      end_a[MAXE];
    int unsigned      end_b[MAXE];
    logic [WB-1:0]    path_max[MAXN][MAXN];

    always #6 clk = ~clk;

    second_best_spanning_tree_cost uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .edge_weight(edge_weight), .final_edge(final_edge),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .second_best_cost(second_best_cost),
        .no_alternative(no_alternative)
    );

    function automatic int unsigned wt(int unsigned k);
        return (k < loaded) ? weights[k] : 0;
    endfunction

    function automatic int unsigned root(int unsigned x);
        int unsigned steps;
        steps = 0;
        while (parent[x] != x && steps < MAXN) begin
            x = parent[x];
            steps++;
        end
        return x;
    endfunction

    // second-best tree cost of the loaded graph; clears the graph afterwards
    function automatic sbst_result_t solve_graph();
        int unsigned n, ne, k, a, b, x, y, j, e, w, ra, rb, kw, pw, prv;
        longint total, best, d;
        sbst_result_t r;
        n = node_reg;
        if (n < 2) n = 2;
        if (n > MAXN) n = MAXN;
        ne = n * (n - 1) / 2;
        k = 0;
        for (a = 0; a + 1 < n; a++)
            for (b = a + 1; b < n; b++)
            begin
                end_a[k] = a;
                end_b[k] = b;
                k++;
            end
        for (k = 0; k < ne; k++)
        begin
            kw = wt(k);
            j = k;
            while (j > 0)
            begin
                prv = order[j-1];
                pw = wt(prv);
                if (pw > kw || (pw == kw && prv > k))
                begin
                    order[j] = prv;
                    j--;
                end
                else
                    break;
            end
            order[j] = k;
        end
        for (x = 0; x < MAXN; x++) parent[x] = x;
        total = 0;
        best = NO_EXTRA;
        for (k = 0; k < ne; k++)
        begin
            e = order[k];
            w = wt(e);
            a = end_a[e];
            b = end_b[e];
            ra = root(a);
            rb = root(b);
            if (ra != rb)
            begin
                total += w;
                for (x = 0; x < n; x++) root_of[x] = root(x);
                for (x = 0; x < n; x++)
                begin
                    if (root_of[x] != ra) continue;
                    for (y = 0; y < n; y++)
                    begin
                        if (root_of[y] != rb) continue;
                        path_max[x][y] = w;
                        path_max[y][x] = w;
                    end
                end
                parent[rb] = ra;
            end
            else
            begin
                d = (w >= path_max[a][b]) ? longint'(w - path_max[a][b]) : 0;
                if (d < best) best = d;
            end
        end
        if (best == NO_EXTRA)
        begin
            r.cost = '0;
            r.noalt = 1'b1;
        end
        else
        begin
            r.cost = COST_W'(total + best);
            r.noalt = 1'b0;
        end
        for (x = 0; x < MAXN; x++) parent[x] = x;
        loaded = 0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        sbst_result_t got, exp_r;
        cycles <= cycles + 1;
        if (rst_n && result_valid)
        begin
            got.cost = second_best_cost;
            got.noalt = no_alternative;
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: cost %0d noalt %0d", got.cost, got.noalt);
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.cost !== exp_r.cost)
                begin
                    $error("second_best_cost expected %0d actual %0d", exp_r.cost, got.cost);
                    failures++;
                end
                if (got.noalt !== exp_r.noalt)
                begin
                    $error("no_alternative expected %0d actual %0d", exp_r.noalt, got.noalt);
                    failures++;
                end
            end
        end
        if (rst_n && cfg_we)
            node_reg = cfg_wdata;
        if (rst_n && start && !busy)
        begin
            if (loaded < MAXE)
            begin
                weights[loaded] = edge_weight;
                loaded++;
            end
            if (final_edge)
            begin
                exp_r = solve_graph();
                if (typed_results.size() > 0)
                    exp_r = typed_results.pop_front();
                expected_results = {expected_results, exp_r};
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(input int unsigned w, input bit fin, input bit gaps);
        int g;
        if (gaps && $urandom_range(99) < 32)
        begin
            start <= 0;
            g = $urandom_range(5, 1);
            repeat (g) @(posedge clk);
        end
        start <= 1;
        edge_weight <= w[WB-1:0];
        final_edge <= fin;
        do @(posedge clk); while (busy);
        beats_sent++;
    endtask

    task automatic write_nodes(input int unsigned v);
        start <= 0;
        @(posedge clk);
        while (expected_results.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    stim_row_t rows[$];

    initial
    begin
        int unsigned n, ne, count, w, i, kind;
        bit gaps;
        sbst_result_t t;
        rows = '{
            '{2,   0,       1, 1, 0,       1},
            '{0,   1048575, 1, 1, 0,       1},
            '{1,   5,       0, 0, 0,       0},
            '{-1,  7,       1, 1, 0,       1},
            '{3,   1048575, 0, 0, 0,       0},
            '{-1,  1048575, 0, 0, 0,       0},
            '{-1,  1048575, 1, 1, 2097150, 0},
            '{-1,  4,       0, 0, 0,       0},
            '{-1,  4,       0, 0, 0,       0},
            '{-1,  4,       1, 1, 8,       0},
            '{-1,  9,       1, 0, 0,       0},
            '{127, 3,       0, 0, 0,       0},
            '{64,  8,       0, 0, 0,       0},
            '{4,   8,       0, 0, 0,       0},
            '{-1,  1,       0, 0, 0,       0},
            '{-1,  8,       0, 0, 0,       0},
            '{-1,  2,       0, 0, 0,       0},
            '{-1,  699050,  0, 0, 0,       0},
            '{-1,  349525,  1, 0, 0,       0}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (rows[r])
        begin
            if (rows[r].cfg >= 0) write_nodes(rows[r].cfg);
            if (rows[r].typed)
            begin
                t.cost = rows[r].cost;
                t.noalt = rows[r].noalt;
                typed_results = {typed_results, t};
            end
            send_beat(rows[r].weight, rows[r].fin, 1);
        end
        count = 0;
        while (count < 500)
        begin
            kind = $urandom_range(99);
            n = (kind < 8) ? $urandom_range(12, 9) : $urandom_range(8, 2);
            if ($urandom_range(19) == 0)
                write_nodes($urandom_range(1));
            else
                write_nodes(n);
            if (node_reg < 2) n = 2;
            ne = n * (n - 1) / 2;
            kind = $urandom_range(99);
            if (kind < 10) ne = $urandom_range(ne, 1);
            else if (kind < 20) ne = ne + $urandom_range(4, 1);
            for (i = 0; i < ne; i++)
            begin
                case ($urandom_range(3))
                    0: w = $urandom_range(3);
                    1: w = $urandom_range(1048575, 1048570);
                    default: w = $urandom() & 20'hFFFFF;
                endcase
                gaps = !(count > 200 && count < 300);
                send_beat(w, i == ne - 1, gaps);
                count++;
            end
        end
        start <= 0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
